@@ hw/rtl/sccache_pkg.sv @@
package sccache_pkg;

  // Default geometry of the cache
  localparam int unsigned CLASS_BYTES = 200;
  localparam int unsigned NUM_CLASSES = 128;
  localparam int unsigned STACK_DEPTH = 128;

  // Widths of the size compare path and of the registers
  localparam int unsigned SIZE_W = 15;
  localparam int unsigned DLIM_W = 8;
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  // Register reset values
  localparam logic              ENABLE_RST = 1'b1;
  localparam logic [SIZE_W-1:0] MAX_SIZE_RST = 15'd20480;
  localparam logic [DLIM_W-1:0] DEPTH_LIMIT_RST = 8'd100;

  typedef enum logic [1:0] {
    REG_ENABLE = 2'd0,
    REG_MAX_SIZE = 2'd1,
    REG_DEPTH_LIMIT = 2'd2
  } reg_idx_e;

  typedef enum logic {
    FN_GET = 1'b0,
    FN_PUT = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ACT_REUSE = 2'd0,
    ACT_ALLOC = 2'd1,
    ACT_FREE = 2'd2,
    ACT_STORE = 2'd3
  } action_e;

  // Classified request kinds handed from the front to the back
  typedef enum logic [1:0] {
    KD_ALLOC_RAW = 2'd0,
    KD_GET = 2'd1,
    KD_FREE = 2'd2,
    KD_PUT = 2'd3
  } kind_e;

  localparam int unsigned KIND_W = 2;
  localparam int unsigned QITEM_W = KIND_W + $clog2(NUM_CLASSES) + 32;

  typedef enum logic [1:0] {
    BK_CLEAR = 2'd0,
    BK_IDLE = 2'd1,
    BK_LOOK = 2'd2,
    BK_POP = 2'd3
  } back_state_e;

  typedef struct packed {
    func_e       func;
    logic [31:0] req_size;
    logic [31:0] handle_in;
  } in_item_t;

  typedef struct packed {
    action_e     action;
    logic [31:0] handle_out;
    logic [31:0] alloc_size;
  } out_item_t;

endpackage

@@ hw/rtl/size_class_free_list_cache.sv @@
// A bypassed get or put is answered straight from the queued item, a cached put or a get
// that misses after the class height memory read, and a get that reuses a handle after the
// handle stack memory read as well. The back end takes a new item only once it has answered
// the last one, and it holds while the output is stalled.
// Reset: registers return to their reset values and a clearing pass over all NUM_CLASSES
// classes empties every class stack; in_stall_o stays high during that pass.
module size_class_free_list_cache #(
  parameter int unsigned CLASS_BYTES = sccache_pkg::CLASS_BYTES,
  parameter int unsigned NUM_CLASSES = sccache_pkg::NUM_CLASSES,
  parameter int unsigned STACK_DEPTH = sccache_pkg::STACK_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sccache_pkg::PADDR_W-1:0] paddr,
  input  logic [sccache_pkg::PDATA_W-1:0] pwdata,
  output logic [sccache_pkg::PDATA_W-1:0] prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  sccache_pkg::in_item_t           in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output sccache_pkg::out_item_t          out_data_o
);

  localparam int unsigned CLS_W = $clog2(NUM_CLASSES);
  localparam int unsigned QW = sccache_pkg::KIND_W + CLS_W + 32;

  sccache_pkg::kind_e             f_kind;
  logic [CLS_W-1:0]               f_cls;
  logic [31:0]                    f_data;
  logic [sccache_pkg::DLIM_W-1:0] depth_limit;
  logic                           q_push;
  logic                           q_full;
  logic                           q_valid;
  logic [QW-1:0]                  q_data;
  logic                           q_pop;
  logic                           clearing;

  assign pready = 1'b1;
  assign in_stall_o = q_full | clearing;
  assign q_push = in_valid_i & !clearing;

  sccache_front #(
    .CLASS_BYTES(CLASS_BYTES),
    .NUM_CLASSES(NUM_CLASSES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .item_i       (in_data_i),
    .kind_o       (f_kind),
    .cls_o        (f_cls),
    .data_o       (f_data),
    .depth_limit_o(depth_limit)
  );

  sccache_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i({f_kind, f_cls, f_data}),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .data_o     (q_data),
    .pop_i      (q_pop)
  );

  sccache_back #(
    .CLASS_BYTES(CLASS_BYTES),
    .NUM_CLASSES(NUM_CLASSES),
    .STACK_DEPTH(STACK_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .depth_limit_i(depth_limit),
    .q_valid_i    (q_valid),
    .kind_i       (sccache_pkg::kind_e'(q_data[QW-1 -: sccache_pkg::KIND_W])),
    .cls_i        (q_data[32 +: CLS_W]),
    .data_i       (q_data[31:0]),
    .q_pop_o      (q_pop),
    .clearing_o   (clearing),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_data_o)
  );

  // No item may reach the queue while the class heights are being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni) clearing |-> !q_valid)
    else $error("queue holds an item during the clearing pass");

  // A reused handle never carries an allocation size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.action == sccache_pkg::ACT_REUSE) |-> out_data_o.alloc_size == '0)
    else $error("reuse result with nonzero alloc size");

  // An allocation result never carries a handle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.action == sccache_pkg::ACT_ALLOC) |-> out_data_o.handle_out == '0)
    else $error("allocate result with nonzero handle");

endmodule

@@ hw/rtl/sccache_front.sv @@
module sccache_front #(
  parameter int unsigned CLASS_BYTES = sccache_pkg::CLASS_BYTES,
  parameter int unsigned NUM_CLASSES = sccache_pkg::NUM_CLASSES
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sccache_pkg::PADDR_W-1:0]    paddr,
  input  logic [sccache_pkg::PDATA_W-1:0]    pwdata,
  output logic [sccache_pkg::PDATA_W-1:0]    prdata,
  input  sccache_pkg::in_item_t              item_i,
  output sccache_pkg::kind_e                 kind_o,
  output logic [$clog2(NUM_CLASSES)-1:0]     cls_o,
  output logic [31:0]                        data_o,
  output logic [sccache_pkg::DLIM_W-1:0]     depth_limit_o
);

  localparam int unsigned CLS_W = $clog2(NUM_CLASSES);
  localparam int unsigned SW = sccache_pkg::SIZE_W;
  localparam int unsigned LG = $clog2(CLASS_BYTES);
  localparam int unsigned SH = SW + LG;
  localparam int unsigned MW = SW + 1;
  localparam int unsigned PW = SW + MW;
  localparam int unsigned QW = PW - SH;
  localparam longint unsigned RECIP =
    ((64'd1 << SH) + 64'(CLASS_BYTES) - 64'd1) / 64'(CLASS_BYTES);

  logic                              enable_q;
  logic [SW-1:0]                     max_size_q;
  logic [sccache_pkg::DLIM_W-1:0]    depth_limit_q;
  logic                              wr_en;
  sccache_pkg::reg_idx_e             reg_idx;

  logic [MW-1:0] recip;
  logic [PW-1:0] prod;
  logic [QW-1:0] quot;
  logic          over;
  logic          bypass;
  logic          get_oob;
  logic          put_oob;

  assign reg_idx = sccache_pkg::reg_idx_e'(paddr[sccache_pkg::PADDR_W-1:2]);
  assign wr_en = psel & penable & pwrite;

  // Write configuration registers on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= sccache_pkg::ENABLE_RST;
      max_size_q <= sccache_pkg::MAX_SIZE_RST;
      depth_limit_q <= sccache_pkg::DEPTH_LIMIT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        sccache_pkg::REG_ENABLE: enable_q <= pwdata[0];
        sccache_pkg::REG_MAX_SIZE: max_size_q <= pwdata[SW-1:0];
        sccache_pkg::REG_DEPTH_LIMIT: depth_limit_q <= pwdata[sccache_pkg::DLIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      sccache_pkg::REG_ENABLE: prdata[0] = enable_q;
      sccache_pkg::REG_MAX_SIZE: prdata[SW-1:0] = max_size_q;
      sccache_pkg::REG_DEPTH_LIMIT: prdata[sccache_pkg::DLIM_W-1:0] = depth_limit_q;
      default: prdata = '0;
    endcase
  end

  assign depth_limit_o = depth_limit_q;

  // Divide the low size bits by the class width with a rounded-up reciprocal;
  // exact for every value below 2**SW, and larger sizes always bypass
  assign recip = MW'(RECIP);
  assign prod = PW'(item_i.req_size[SW-1:0]) * PW'(recip);
  assign quot = prod[PW-1:SH];

  assign over = (item_i.req_size[31:SW] != '0) || (item_i.req_size[SW-1:0] >= max_size_q);
  assign bypass = !enable_q || over;
  assign get_oob = 32'(quot) >= NUM_CLASSES;
  assign put_oob = (quot == '0) || (32'(quot) > NUM_CLASSES);

  // Classify the item
  always_comb begin
    kind_o = sccache_pkg::KD_ALLOC_RAW;
    cls_o = '0;
    data_o = item_i.req_size;
    if (item_i.func == sccache_pkg::FN_GET) begin
      if (!(bypass || get_oob)) begin
        kind_o = sccache_pkg::KD_GET;
        cls_o = CLS_W'(32'(quot));
      end
    end else begin
      data_o = item_i.handle_in;
      if (bypass || put_oob) begin
        kind_o = sccache_pkg::KD_FREE;
      end else begin
        kind_o = sccache_pkg::KD_PUT;
        cls_o = CLS_W'(32'(quot) - 32'd1);
      end
    end
  end

endmodule

@@ hw/rtl/sccache_queue.sv @@
module sccache_queue #(
  parameter int unsigned WIDTH = sccache_pkg::QITEM_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o,
  input  logic             pop_i
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             do_push;
  logic             do_pop;

  assign full_o = cnt_q[1];
  assign valid_o = cnt_q != 2'd0;
  assign data_o = mem_q[rd_ptr_q];
  assign do_push = push_i & !full_o;
  assign do_pop = pop_i & valid_o;

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop) rd_ptr_q <= !rd_ptr_q;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  // Hold queued items
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

@@ hw/rtl/sccache_back.sv @@
module sccache_back #(
  parameter int unsigned CLASS_BYTES = sccache_pkg::CLASS_BYTES,
  parameter int unsigned NUM_CLASSES = sccache_pkg::NUM_CLASSES,
  parameter int unsigned STACK_DEPTH = sccache_pkg::STACK_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [sccache_pkg::DLIM_W-1:0] depth_limit_i,
  input  logic                           q_valid_i,
  input  sccache_pkg::kind_e             kind_i,
  input  logic [$clog2(NUM_CLASSES)-1:0] cls_i,
  input  logic [31:0]                    data_i,
  output logic                           q_pop_o,
  output logic                           clearing_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output sccache_pkg::out_item_t         out_item_o
);

  localparam int unsigned CLS_W = $clog2(NUM_CLASSES);
  localparam int unsigned HW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(NUM_CLASSES * STACK_DEPTH);

  sccache_pkg::back_state_e st_q, st_d;
  logic [CLS_W-1:0]         clr_q;
  logic                     out_valid_q;
  sccache_pkg::out_item_t   out_item_q;
  sccache_pkg::kind_e       kind_q;
  logic [CLS_W-1:0]         cls_q;
  logic [31:0]              data_q;

  logic [HW-1:0]            hgt_mem [NUM_CLASSES];
  logic [HW-1:0]            hgt_rd_q;
  logic [31:0]              stk_mem [NUM_CLASSES * STACK_DEPTH];
  logic [31:0]              stk_rd_q;

  logic                     out_free;
  logic                     h_zero;
  logic                     put_full;
  logic [AW-1:0]            stk_base;
  logic [31:0]              class_size;

  logic                     load_work;
  logic                     hgt_re;
  logic                     hgt_we;
  logic [CLS_W-1:0]         hgt_waddr;
  logic [HW-1:0]            hgt_wdata;
  logic                     stk_re;
  logic                     stk_we;
  logic [AW-1:0]            stk_addr;
  logic                     res_en;
  sccache_pkg::out_item_t   res_item;

  assign out_free = !out_valid_q || !out_stall_i;
  assign h_zero = hgt_rd_q == '0;
  assign put_full = (32'(hgt_rd_q) >= 32'(depth_limit_i)) || (32'(hgt_rd_q) >= STACK_DEPTH);
  assign stk_base = AW'(32'(cls_q) * STACK_DEPTH);
  assign class_size = 32'(CLASS_BYTES) * (32'(cls_q) + 32'd1);
  assign clearing_o = st_q == sccache_pkg::BK_CLEAR;

  // Next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      sccache_pkg::BK_CLEAR: begin
        if (32'(clr_q) == NUM_CLASSES - 1) st_d = sccache_pkg::BK_IDLE;
      end
      sccache_pkg::BK_IDLE: begin
        if (q_valid_i && (kind_i == sccache_pkg::KD_GET || kind_i == sccache_pkg::KD_PUT)) begin
          st_d = sccache_pkg::BK_LOOK;
        end
      end
      sccache_pkg::BK_LOOK: begin
        if (out_free) begin
          if (kind_q == sccache_pkg::KD_GET && !h_zero) begin
            st_d = sccache_pkg::BK_POP;
          end else begin
            st_d = sccache_pkg::BK_IDLE;
          end
        end
      end
      sccache_pkg::BK_POP: begin
        if (out_free) st_d = sccache_pkg::BK_IDLE;
      end
      default: st_d = sccache_pkg::BK_IDLE;
    endcase
  end

  // Memory strobes, queue pop and result
  always_comb begin
    q_pop_o = 1'b0;
    load_work = 1'b0;
    hgt_re = 1'b0;
    hgt_we = 1'b0;
    hgt_waddr = cls_q;
    hgt_wdata = '0;
    stk_re = 1'b0;
    stk_we = 1'b0;
    stk_addr = stk_base + AW'(hgt_rd_q);
    res_en = 1'b0;
    res_item.action = sccache_pkg::ACT_ALLOC;
    res_item.handle_out = '0;
    res_item.alloc_size = '0;
    unique case (st_q)
      sccache_pkg::BK_CLEAR: begin
        hgt_we = 1'b1;
        hgt_waddr = clr_q;
      end
      sccache_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          unique case (kind_i) inside
            sccache_pkg::KD_GET, sccache_pkg::KD_PUT: begin
              q_pop_o = 1'b1;
              load_work = 1'b1;
              hgt_re = 1'b1;
            end
            sccache_pkg::KD_ALLOC_RAW: begin
              if (out_free) begin
                q_pop_o = 1'b1;
                res_en = 1'b1;
                res_item.alloc_size = data_i;
              end
            end
            sccache_pkg::KD_FREE: begin
              if (out_free) begin
                q_pop_o = 1'b1;
                res_en = 1'b1;
                res_item.action = sccache_pkg::ACT_FREE;
                res_item.handle_out = data_i;
              end
            end
            default: ;
          endcase
        end
      end
      sccache_pkg::BK_LOOK: begin
        if (out_free) begin
          if (kind_q == sccache_pkg::KD_GET) begin
            if (h_zero) begin
              res_en = 1'b1;
              res_item.alloc_size = class_size;
            end else begin
              // Pop: lower the height and read the top entry
              hgt_we = 1'b1;
              hgt_wdata = hgt_rd_q - HW'(1);
              stk_re = 1'b1;
              stk_addr = stk_base + AW'(hgt_rd_q - HW'(1));
            end
          end else if (put_full) begin
            res_en = 1'b1;
            res_item.action = sccache_pkg::ACT_FREE;
            res_item.handle_out = data_q;
          end else begin
            // Push: write the handle above the top and raise the height
            hgt_we = 1'b1;
            hgt_wdata = hgt_rd_q + HW'(1);
            stk_we = 1'b1;
            res_en = 1'b1;
            res_item.action = sccache_pkg::ACT_STORE;
            res_item.handle_out = data_q;
          end
        end
      end
      sccache_pkg::BK_POP: begin
        if (out_free) begin
          res_en = 1'b1;
          res_item.action = sccache_pkg::ACT_REUSE;
          res_item.handle_out = stk_rd_q;
        end
      end
      default: ;
    endcase
  end

  // Sequencer state, clear sweep and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= sccache_pkg::BK_CLEAR;
      clr_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == sccache_pkg::BK_CLEAR) clr_q <= clr_q + CLS_W'(1);
      if (res_en) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the working item and the result
  always_ff @(posedge clk_i) begin
    if (load_work) begin
      kind_q <= kind_i;
      cls_q <= cls_i;
      data_q <= data_i;
    end
    if (res_en) out_item_q <= res_item;
  end

  // Class height memory
  always_ff @(posedge clk_i) begin
    if (hgt_we) hgt_mem[hgt_waddr] <= hgt_wdata;
    if (hgt_re) hgt_rd_q <= hgt_mem[cls_i];
  end

  // Handle stack memory
  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_addr] <= data_q;
    if (stk_re) stk_rd_q <= stk_mem[stk_addr];
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o = out_item_q;

endmodule

@@ bench/tb_size_class_free_list_cache.sv @@
`timescale 1ns / 100ps

module tb_size_class_free_list_cache;
  import sccache_pkg::*;

  localparam int unsigned HOLD_AT = 60;
  localparam int unsigned HOLD_LEN = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_data_o;

  // Shadow copy of the registers and the class stacks
  logic cfg_enable = ENABLE_RST;
  logic [SIZE_W-1:0] cfg_max_size = MAX_SIZE_RST;
  logic [DLIM_W-1:0] cfg_depth_limit = DEPTH_LIMIT_RST;
  int unsigned class_height [NUM_CLASSES];
  logic [31:0] class_stack [NUM_CLASSES][STACK_DEPTH];

  in_item_t request_q [$];
  out_item_t due_results [$];

  int unsigned snd_idle_pct = 9;
  int unsigned rcv_idle_pct = 71;
  int unsigned n_accepted = 0;
  int unsigned n_results = 0;
  int unsigned n_errors = 0;
  int unsigned n_writes = 0;
  int unsigned act_count [4];
  int unsigned hold_left = 0;
  bit hold_done = 1'b0;

  size_class_free_list_cache uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Work out the answer to one request and advance the shadow stacks
  function automatic out_item_t serve_request(in_item_t it);
    out_item_t r;
    logic bypass;
    int unsigned cls;
    r.action = ACT_ALLOC;
    r.handle_out = '0;
    r.alloc_size = '0;
    bypass = !cfg_enable || (it.req_size >= 32'(cfg_max_size));
    cls = it.req_size / CLASS_BYTES;
    if (it.func == FN_GET) begin
      if (bypass || cls >= NUM_CLASSES) begin
        r.alloc_size = it.req_size;
      end else if (class_height[cls] == 0) begin
        r.alloc_size = CLASS_BYTES * (cls + 1);
      end else begin
        class_height[cls]--;
        r.action = ACT_REUSE;
        r.handle_out = class_stack[cls][class_height[cls]];
      end
    end else begin
      r.action = ACT_FREE;
      r.handle_out = it.handle_in;
      if (!bypass && cls != 0 && cls - 1 < NUM_CLASSES &&
          class_height[cls-1] < cfg_depth_limit && class_height[cls-1] < STACK_DEPTH) begin
        class_stack[cls-1][class_height[cls-1]] = it.handle_in;
        class_height[cls-1]++;
        r.action = ACT_STORE;
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      n_errors++;
      $display("%0t mismatch on %s: expected %h, got %h", $time, name, want, got);
    end
  endtask

  // Driver: offer queued items, predict each one as it is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        due_results.push_back(serve_request(in_data_i));
        n_accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (request_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i <= request_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result taken, then choose the next stall
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (due_results.size() == 0) begin
          n_errors++;
          $display("%0t unexpected result: expected none, got %p", $time, out_data_o);
        end else begin
          want = due_results.pop_front();
          check_field("action", 32'(want.action), 32'(out_data_o.action));
          check_field("handle_out", want.handle_out, out_data_o.handle_out);
          check_field("alloc_size", want.alloc_size, out_data_o.alloc_size);
          act_count[want.action]++;
          n_results++;
        end
      end
      // Long hold-off once the input side has got going, so the block backs up
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!hold_done && n_accepted >= HOLD_AT) begin
        out_stall_i <= 1'b1;
        hold_left <= HOLD_LEN;
        hold_done <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < rcv_idle_pct);
      end
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(4 * int'(idx));
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ENABLE: cfg_enable = value[0];
      REG_MAX_SIZE: cfg_max_size = value[SIZE_W-1:0];
      REG_DEPTH_LIMIT: cfg_depth_limit = value[DLIM_W-1:0];
      default: ;
    endcase
    n_writes++;
  endtask

  task automatic queue_item(func_e f, logic [31:0] sz, logic [31:0] h);
    in_item_t it;
    it.func = f;
    it.req_size = sz;
    it.handle_in = h;
    request_q.push_back(it);
  endtask

  // Hold until every queued item is taken and every result is back
  task automatic wait_drained();
    while (request_q.size() != 0 || in_valid_i || due_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
  endtask

  // Mostly sizes within the first n_cls classes, some boundaries, some noise
  task automatic queue_random(int unsigned count, int unsigned n_cls);
    in_item_t it;
    int unsigned pick;
    int unsigned cls;
    repeat (count) begin
      pick = $urandom_range(99);
      it.func = func_e'($urandom_range(1));
      it.handle_in = $urandom();
      if (pick < 8) begin
        it.req_size = $urandom();
      end else if (pick < 16) begin
        case ($urandom_range(6))
          0: it.req_size = 32'd0;
          1: it.req_size = CLASS_BYTES - 1;
          2: it.req_size = CLASS_BYTES;
          3: it.req_size = 32'(cfg_max_size) - 1;
          4: it.req_size = 32'(cfg_max_size);
          5: it.req_size = 32'd25599;
          default: it.req_size = 32'd25600;
        endcase
      end else begin
        cls = $urandom_range(n_cls - 1);
        it.req_size = cls * CLASS_BYTES + $urandom_range(CLASS_BYTES - 1);
        if (it.func == FN_PUT) it.req_size += CLASS_BYTES;
      end
      request_q.push_back(it);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Wait out the clearing pass
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);

    // Reset settings: misses, too-small puts, bypass, extremes, LIFO order
    queue_item(FN_GET, 32'd0, 32'h0);
    queue_item(FN_PUT, 32'd199, 32'hFFFF_FFFF);
    queue_item(FN_PUT, 32'd200, 32'h0000_0001);
    queue_item(FN_GET, 32'd0, 32'h0);
    queue_item(FN_PUT, 32'd20479, 32'hA5A5_A5A5);
    queue_item(FN_GET, 32'd20200, 32'h0);
    queue_item(FN_GET, 32'd20480, 32'h0);
    queue_item(FN_PUT, 32'hFFFF_FFFF, 32'h0);
    queue_item(FN_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_item(FN_PUT, 32'd400, 32'h0000_0011);
    queue_item(FN_PUT, 32'd599, 32'h0000_0022);
    queue_item(FN_GET, 32'd200, 32'h0);
    queue_item(FN_GET, 32'd399, 32'h0);
    queue_item(FN_PUT, 32'd1000, 32'h0000_0031);
    queue_item(FN_PUT, 32'd1000, 32'h0000_0032);
    queue_item(FN_PUT, 32'd1000, 32'h0000_0033);
    wait_drained();

    // Lower the depth limit below a stack that already holds three handles
    write_reg(REG_DEPTH_LIMIT, 32'd1);
    queue_item(FN_PUT, 32'd1000, 32'h0000_0034);
    repeat (4) queue_item(FN_GET, 32'd800, 32'h0);
    wait_drained();

    // Widest size limit: class indices run past the last class
    write_reg(REG_MAX_SIZE, 32'd32767);
    write_reg(REG_DEPTH_LIMIT, 32'd128);
    queue_item(FN_GET, 32'd25600, 32'h0);
    queue_item(FN_PUT, 32'd25800, 32'h0000_0041);
    queue_item(FN_PUT, 32'd25600, 32'h0000_0042);
    queue_item(FN_GET, 32'd25400, 32'h0);
    wait_drained();

    // Cache off, set through a value with every bit but bit 0 high
    write_reg(REG_ENABLE, 32'hFFFF_FFFE);
    queue_item(FN_GET, 32'd100, 32'h0);
    queue_item(FN_PUT, 32'd400, 32'h0000_0051);
    wait_drained();

    // Zero size limit bypasses everything
    write_reg(REG_ENABLE, 32'd1);
    write_reg(REG_MAX_SIZE, 32'd0);
    queue_item(FN_GET, 32'd0, 32'h0);
    wait_drained();

    // Fill one class to the stack depth while the output is held off
    write_reg(REG_MAX_SIZE, 32'd25600);
    repeat (130) queue_item(FN_PUT, 32'd600 + $urandom_range(199), $urandom());
    wait_drained();
    repeat (130) queue_item(FN_GET, 32'd400 + $urandom_range(199), $urandom());
    wait_drained();

    // Shallow stacks over a few classes; sender now mostly idle
    snd_idle_pct = 71;
    rcv_idle_pct = 9;
    write_reg(REG_MAX_SIZE, 32'd20480);
    write_reg(REG_DEPTH_LIMIT, 32'd4);
    queue_random(210, 8);
    wait_drained();

    // Full speed on both sides, mid-range limit, many classes
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    write_reg(REG_MAX_SIZE, 32'd12000);
    write_reg(REG_DEPTH_LIMIT, 32'd100);
    queue_random(210, 64);
    wait_drained();

    write_reg(REG_ENABLE, 32'd0);
    queue_random(40, 8);
    wait_drained();

    $display("Checked %0d results for %0d items over %0d register writes.",
             n_results, n_accepted, n_writes);
    $display("Reuse %0d, allocate %0d, free %0d, store %0d; long output hold done: %0d.",
             act_count[ACT_REUSE], act_count[ACT_ALLOC], act_count[ACT_FREE],
             act_count[ACT_STORE], hold_done);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d results outstanding.", due_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
